### rtl/lzd_pkg.sv
// lzd_pkg: shared types and constants for the lz77 token decoder
// state encoding and the command/status bundles between controller and datapath
// no dependencies
package lzd_pkg;

    localparam int OFFSET_W   = 13;
    localparam int LENGTH_W   = 6;
    localparam int BYTE_W     = 8;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    localparam logic [BYTE_W-1:0] NO_LITERAL = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_LIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mem_read;
        logic emit_copy;
        logic emit_lit;
    } lzd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_len_zero;
        logic in_lit_zero;
        logic len_one;
        logic lit_zero;
        logic out_free;
    } lzd_stat_t;

endpackage

### rtl/lzd_ctrl.sv
// lzd_ctrl: token sequencer for the lz77 token decoder
// walks each token through history reads, copied bytes and the literal
// depends on lzd_pkg
module lzd_ctrl
    import lzd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  lzd_stat_t stat,
    output lzd_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (!stat.in_len_zero) begin
                        state_next = ST_READ;
                    end else if (!stat.in_lit_zero) begin
                        state_next = ST_LIT;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_COPY;
            end
            ST_COPY: begin
                if (stat.out_free) begin
                    if (!stat.len_one) begin
                        state_next = ST_READ;
                    end else if (!stat.lit_zero) begin
                        state_next = ST_LIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
            end
            ST_COPY: begin
                cmd.emit_copy = stat.out_free;
            end
            ST_LIT: begin
                cmd.emit_lit = stat.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/lzd_datapath.sv
// lzd_datapath: history memory, pointers, token registers and output register
// executes the commands of lzd_ctrl and reports token status back
// depends on lzd_pkg
module lzd_datapath
    import lzd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [OFFSET_W-1:0]  in_offset,
    input  logic [LENGTH_W-1:0]  in_length,
    input  logic [BYTE_W-1:0]    in_literal,
    input  lzd_cmd_t             cmd,
    output lzd_stat_t            stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 out_last,
    output logic                 out_bad
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

    logic [BYTE_W-1:0] hist_mem [HISTORY_DEPTH];

    logic [OFFSET_W-1:0] off_reg;
    logic [LENGTH_W-1:0] len_reg;
    logic [BYTE_W-1:0]   lit_reg;
    logic [AW-1:0]       wp_reg;
    logic [AW-1:0]       wp_next;
    logic [CNT_W-1:0]    produced_reg;
    logic [CNT_W-1:0]    produced_next;
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                bad_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic                out_bad_reg;

    logic [LENGTH_W-1:0] len_clamped;
    logic [CMP_W-1:0]    off_ext;
    logic [CMP_W-1:0]    wp_ext;
    logic [CMP_W-1:0]    rd_addr_full;
    logic [AW-1:0]       rd_addr;
    logic                bad_now;
    logic [BYTE_W-1:0]   copy_byte;
    logic [BYTE_W-1:0]   wr_byte;
    logic                emit;
    logic                out_free;

    assign len_clamped = (in_length > LENGTH_W'(MAX_MATCH)) ? LENGTH_W'(MAX_MATCH) : in_length;

    assign off_ext = CMP_W'(off_reg);
    assign wp_ext  = CMP_W'(wp_reg);
    // an offset past the bytes produced so far also covers past-depth offsets; zero is checked apart
    assign bad_now = (off_ext == '0) || (off_ext > CMP_W'(produced_reg));
    // wrap without exceeding the depth, valid whenever the reference is good
    assign rd_addr_full = (wp_ext >= off_ext) ? (wp_ext - off_ext)
                                              : (CMP_W'(HISTORY_DEPTH) - (off_ext - wp_ext));
    assign rd_addr = rd_addr_full[AW-1:0];

    assign copy_byte = bad_reg ? '0 : rd_data_reg;
    assign wr_byte   = cmd.emit_lit ? lit_reg : copy_byte;
    assign emit      = cmd.emit_copy | cmd.emit_lit;
    assign out_free  = !out_valid_reg || out_ready;

    assign wp_next       = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign produced_next = (produced_reg == CNT_W'(HISTORY_DEPTH)) ? produced_reg
                                                                   : produced_reg + 1'b1;

    // history store, read data registered
    always_ff @(posedge aclk) begin
        if (emit) begin
            hist_mem[wp_reg] <= wr_byte;
        end
        if (cmd.mem_read) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_read) begin
            bad_reg <= bad_now;
        end
        if (cmd.load) begin
            off_reg <= in_offset;
            len_reg <= len_clamped;
            lit_reg <= in_literal;
        end else if (cmd.emit_copy) begin
            len_reg <= len_reg - 1'b1;
        end
        if (emit) begin
            out_byte_reg <= wr_byte;
            out_last_reg <= cmd.emit_lit || ((len_reg == LENGTH_W'(1)) && (lit_reg == NO_LITERAL));
            out_bad_reg  <= cmd.emit_copy && bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg        <= '0;
            produced_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                wp_reg       <= wp_next;
                produced_reg <= produced_next;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.in_len_zero = (in_length == '0);
    assign stat.in_lit_zero = (in_literal == NO_LITERAL);
    assign stat.len_one     = (len_reg == LENGTH_W'(1));
    assign stat.lit_zero    = (lit_reg == NO_LITERAL);
    assign stat.out_free    = out_free;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

    a_produced_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        produced_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("byte count beyond history depth");

    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("beat emitted over an untaken result");

    a_produced_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (produced_reg != CNT_W'(HISTORY_DEPTH)))
            |=> (produced_reg == CNT_W'($past(produced_reg) + 1'b1)))
        else $error("byte count did not follow emitted byte");

    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.emit_copy && cmd.emit_lit) && !(cmd.load && (emit || cmd.mem_read)))
        else $error("conflicting datapath commands");

endmodule

### rtl/lz77_token_decoder.sv
// lz77_token_decoder: top level, ties the sequencer to the datapath
// depends on lzd_pkg, lzd_ctrl, lzd_datapath
//
// Decodes one LZ77 token per input beat into a stream of byte beats. Each
// copied byte takes a history read whose data is registered, then the
// write-back and output, which wait while the output register is full; the
// literal then takes a write-back and output of its own. The input is
// only ready between tokens. A result register sits on the output, so the
// next token may be taken while the last byte still waits. Offsets that reach
// before the first byte produced (or are zero) yield zero bytes flagged on
// m_tuser. No clearing pass is needed after reset: the byte count guards all
// reads of unwritten history.
module lz77_token_decoder
    import lzd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // match_offset, match_length, literal_byte, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_byte
    output logic                  m_tlast,
    output logic                  m_tuser    // bad_reference
);

    localparam int LEN_LO = OFFSET_W;
    localparam int LIT_LO = OFFSET_W + LENGTH_W;

    lzd_cmd_t  cmd;
    lzd_stat_t stat;

    lzd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lzd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .MAX_MATCH     (MAX_MATCH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_offset  (s_tdata[OFFSET_W-1:0]),
        .in_length  (s_tdata[LEN_LO +: LENGTH_W]),
        .in_literal (s_tdata[LIT_LO +: BYTE_W]),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_bad    (m_tuser)
    );

endmodule

### test/lzd_stream_checker.sv
`timescale 1ns / 100ps
// lzd_stream_checker: watches both streams of the lz77 token decoder, predicts
// the decoded bytes of each accepted token and compares them with the output beats
// depends on lzd_pkg
module lzd_stream_checker
    import lzd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4096,
    parameter int MAX_MATCH     = 63
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // match_offset, match_length, literal_byte, zero pad
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // out_byte
    input  logic                 m_tlast,
    input  logic                 m_tuser,   // bad_reference
    output int                   mismatches,
    output int                   beats_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              bad;
    } decoded_t;

    logic [BYTE_W-1:0] history [HISTORY_DEPTH];
    int                wr_ptr;
    int                produced;
    decoded_t          expected_bytes [$];

    function automatic void store_byte(logic [BYTE_W-1:0] b);
        history[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
        if (produced < HISTORY_DEPTH)
            produced = produced + 1;
    endfunction

    // appends one predicted beat at the tail of the queue
    function automatic void queue_beat(decoded_t d);
        expected_bytes.insert(expected_bytes.size(), d);
    endfunction

    // expands one token into the bytes it must produce, updating the history
    function automatic void decode_token(logic [OFFSET_W-1:0] off, logic [LENGTH_W-1:0] len,
                                         logic [BYTE_W-1:0] lit);
        int               n;
        int               total;
        bit               bad;
        logic [BYTE_W-1:0] b;
        decoded_t         d;
        n = (len > MAX_MATCH) ? MAX_MATCH : int'(len);
        total = n + ((lit != NO_LITERAL) ? 1 : 0);
        for (int i = 0; i < n; i++) begin
            // the byte count grows during the copy, so a long copy can become valid
            bad = (off == 0) || (off > HISTORY_DEPTH) || (int'(off) > produced);
            b = bad ? '0 : history[(wr_ptr + HISTORY_DEPTH - int'(off)) % HISTORY_DEPTH];
            d.value = b;
            d.last = (i == total - 1);
            d.bad = bad;
            queue_beat(d);
            store_byte(b);
        end
        if (lit != NO_LITERAL) begin
            d.value = lit;
            d.last = 1'b1;
            d.bad = 1'b0;
            queue_beat(d);
            store_byte(lit);
        end
    endfunction

    always @(posedge aclk) begin
        decoded_t want;
        if (!aresetn) begin
            for (int a = 0; a < HISTORY_DEPTH; a++)
                history[a] = '0;
            wr_ptr = 0;
            produced = 0;
            expected_bytes.delete();
        end else begin
            // an output beat always belongs to a token taken at an earlier edge
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected beat byte=%02h last=%b bad=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last ||
                        m_tuser !== want.bad) begin
                        if (mismatches < 10)
                            $display("%0t: expected %02h/%b/%b got %02h/%b/%b",
                                     $realtime, want.value, want.last, want.bad,
                                     m_tdata, m_tlast, m_tuser);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                decode_token(s_tdata[OFFSET_W-1:0],
                             s_tdata[OFFSET_W +: LENGTH_W],
                             s_tdata[OFFSET_W+LENGTH_W +: BYTE_W]);
        end
        beats_pending = expected_bytes.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// tb: top of the lz77 token decoder testbench, drives tokens and output backpressure
// depends on lzd_pkg, lz77_token_decoder and lzd_stream_checker
module tb;
    import lzd_pkg::*;

    localparam int HIST          = 4096;
    localparam int MAXLEN        = 63;
    localparam int STALL_LIMIT   = 6000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RANDOM_TOKENS = 450;
    localparam int PAD_W         = S_TDATA_W - OFFSET_W - LENGTH_W - BYTE_W;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int mismatches;
    int beats_pending;
    int out_beats    = 0;
    int quiet_cycles = 0;
    int made         = 0;   // bytes produced so far, saturating like the history
    bit steady       = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    lz77_token_decoder #(
        .HISTORY_DEPTH(HIST),
        .MAX_MATCH    (MAXLEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    lzd_stream_checker #(
        .HISTORY_DEPTH(HIST),
        .MAX_MATCH    (MAXLEN)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .beats_pending(beats_pending)
    );

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (m_tvalid && m_tready)
            out_beats <= out_beats + 1;
    end

    // output backpressure, with one long hold-off to fill the block up
    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && out_beats >= 1500) begin
                held = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = steady || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic send_token(input logic [OFFSET_W-1:0] off, input logic [LENGTH_W-1:0] len,
                              input logic [BYTE_W-1:0] lit);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_tvalid = 1'b0;
            s_tdata = $urandom;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{PAD_W{1'b0}}, lit, len, off};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        made = made + int'(len) + ((lit != NO_LITERAL) ? 1 : 0);
        if (made > HIST)
            made = HIST;
    endtask

    initial begin : stimulus
        int                  pick;
        int                  reach;
        logic [OFFSET_W-1:0] off;
        logic [LENGTH_W-1:0] len;
        logic [BYTE_W-1:0]   lit;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed tokens
        send_token(1, 5, 8'h41);          // copy before the start, turns valid after one byte
        send_token(0, 0, 8'h42);          // literal only
        send_token(0, 0, NO_LITERAL);     // empty token
        send_token(8191, 0, NO_LITERAL);  // empty token, offset ignored
        send_token(1, 10, 8'h43);         // overlapping run
        send_token(2, 7, NO_LITERAL);     // copy with no literal
        send_token(0, 4, NO_LITERAL);     // offset zero
        send_token(0, 3, 8'hff);
        send_token(8191, 3, 8'h80);       // offset beyond the history
        send_token(4097, 2, 8'h01);
        send_token(4096, 2, 8'h7f);       // largest nominal offset, still before the start
        send_token(5, 0, 8'h7e);          // offset ignored when length is zero
        send_token(OFFSET_W'(made + 1), 4, 8'h55);   // just past the bytes produced
        send_token(OFFSET_W'(made), 6, 8'haa);       // exactly the first byte produced
        send_token(3, 63, 8'h01);         // longest match
        send_token(64, 63, NO_LITERAL);
        send_token(OFFSET_W'(made), 63, 8'hfe);
        send_token(17, 1, 8'h10);
        send_token(1, 1, NO_LITERAL);
        send_token(100, 32, 8'h20);

        for (int k = 0; k < RANDOM_TOKENS; k++) begin
            steady = (k >= 200 && k < 280);
            // let the block drain completely once in the middle of the run
            if (k == 350) begin
                s_tvalid = 1'b0;
                while (beats_pending != 0) @(negedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10)
                len = '0;
            else if (pick < 15)
                len = LENGTH_W'(MAXLEN);
            else if (pick < 30)
                len = LENGTH_W'($urandom_range(17, MAXLEN));
            else
                len = LENGTH_W'($urandom_range(1, 16));
            reach = (made < 1) ? 1 : made;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                off = OFFSET_W'($urandom_range(1, (reach < 64) ? reach : 64));
            else if (pick < 80)
                off = OFFSET_W'($urandom_range(1, reach));
            else if (pick < 88)
                off = OFFSET_W'(HIST);
            else if (pick < 93)
                off = OFFSET_W'(made + int'($urandom_range(1, 3)));
            else if (pick < 97)
                off = '0;
            else
                off = OFFSET_W'($urandom_range(HIST + 1, (1 << OFFSET_W) - 1));
            lit = ($urandom_range(0, 3) == 0) ? NO_LITERAL : BYTE_W'($urandom_range(1, 255));
            send_token(off, len, lit);
        end
        steady = 1'b0;
        s_tvalid = 1'b0;

        while (beats_pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### lz77_token_decoder.f
rtl/lzd_pkg.sv
rtl/lzd_ctrl.sv
rtl/lzd_datapath.sv
rtl/lz77_token_decoder.sv
test/lzd_stream_checker.sv
test/tb.sv
